// ----- src/rtts_pkg.sv -----
// Package for the ready and timer task scheduler.
// Holds depths, widths, request and result codes and the control/status structs.
// No dependencies.
package rtts_pkg;
  localparam int READY_DEPTH = 16;
  localparam int SLEEP_DEPTH = 16;
  localparam int TIME_BITS = 32;
  localparam int MAX_RESULTS = 32;
  localparam int RIDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int RCNT_W = $clog2(READY_DEPTH + 1);
  localparam int SIDX_W = (SLEEP_DEPTH > 1) ? $clog2(SLEEP_DEPTH) : 1;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_SOON = 2'd0;
  localparam logic [1:0] REQ_LATER = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] RES_ACCEPT = 2'd0;
  localparam logic [1:0] RES_REJECT = 2'd1;
  localparam logic [1:0] RES_DISPATCH = 2'd2;

  typedef struct packed {
    logic load;
    logic do_soon;
    logic do_later;
    logic do_tick;
    logic scan_start;
    logic scan_step;
    logic emit_ready;
    logic emit_sleep;
    logic flush;
    logic out_take;
  } rtts_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic ready_left;
    logic scan_done;
    logic found;
    logic budget_left;
    logic pend_full;
    logic out_full;
  } rtts_sts_t;
endpackage

// ----- src/rtts_datapath.sv -----
// Datapath of the scheduler: ready FIFO, sleep slots, time counter, due scan,
// a staging register for the newest dispatch and the output register.
// Depends on rtts_pkg.
module rtts_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_task_id,
  input  logic [15:0]         in_delay_ticks,
  input  rtts_pkg::rtts_cmd_t cmd,
  output rtts_pkg::rtts_sts_t sts,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_task,
  output logic                out_last
);
  import rtts_pkg::*;

  logic [7:0] rfifo [READY_DEPTH];
  logic [7:0] sid [SLEEP_DEPTH];
  logic [TIME_BITS-1:0] sdl [SLEEP_DEPTH];
  logic [SLEEP_DEPTH-1:0] svalid_r;
  logic [RCNT_W-1:0] rcount_r, rpos_r;
  logic [TIME_BITS-1:0] now_r;
  logic [1:0] req_r;
  logic [7:0] task_r;
  logic [15:0] delay_r;
  logic [SIDX_W:0] scan_r;
  logic found_r;
  logic [SIDX_W-1:0] best_r;
  logic [TIME_BITS-1:0] best_el_r;
  logic [NRES_W-1:0] nres_r;
  logic ov_r, olast_r;
  logic [1:0] okind_r;
  logic [7:0] otask_r;
  logic pend_v_r;
  logic [7:0] pend_task_r;
  logic load_out;
  logic free_found;
  logic [SIDX_W-1:0] free_idx;
  logic [SIDX_W-1:0] sidx;
  logic [TIME_BITS-1:0] el;
  logic due, better;
  logic [7:0] rhead;

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int s = SLEEP_DEPTH - 1; s >= 0; s--) begin
      if (!svalid_r[s]) begin
        free_found = 1'b1;
        free_idx = SIDX_W'(s);
      end
    end
  end

  assign sidx = scan_r[SIDX_W-1:0];
  assign el = now_r - sdl[sidx];
  assign due = svalid_r[sidx] && !el[TIME_BITS-1];
  assign better = due && (!found_r || el > best_el_r);
  assign rhead = rfifo[rpos_r[RIDX_W-1:0]];

  // The output register is loaded with a request's acknowledge, or with the
  // staged dispatch when a newer dispatch replaces it or when the tick ends.
  assign load_out = cmd.do_soon || cmd.do_later || cmd.flush ||
                    ((cmd.emit_ready || cmd.emit_sleep) && pend_v_r);

  assign sts.req = req_r;
  assign sts.ready_left = rpos_r < rcount_r;
  assign sts.scan_done = scan_r == (SIDX_W+1)'(SLEEP_DEPTH);
  assign sts.found = found_r;
  assign sts.budget_left = nres_r < NRES_W'(MAX_RESULTS);
  assign sts.pend_full = pend_v_r;
  assign sts.out_full = ov_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      task_r <= in_task_id;
      delay_r <= in_delay_ticks;
    end
    if (cmd.do_soon && rcount_r < RCNT_W'(READY_DEPTH)) begin
      rfifo[rcount_r[RIDX_W-1:0]] <= task_r;
    end
    if (cmd.do_later && free_found) begin
      sid[free_idx] <= task_r;
      sdl[free_idx] <= now_r + TIME_BITS'(delay_r);
    end
    if (cmd.do_soon) begin
      okind_r <= (rcount_r < RCNT_W'(READY_DEPTH)) ? RES_ACCEPT : RES_REJECT;
      otask_r <= task_r;
      olast_r <= 1'b1;
    end else if (cmd.do_later) begin
      okind_r <= free_found ? RES_ACCEPT : RES_REJECT;
      otask_r <= task_r;
      olast_r <= 1'b1;
    end else if (load_out) begin
      okind_r <= RES_DISPATCH;
      otask_r <= pend_task_r;
      olast_r <= cmd.flush;
    end
    if (cmd.emit_ready) begin
      pend_task_r <= rhead;
    end else if (cmd.emit_sleep) begin
      pend_task_r <= sid[best_r];
    end
    if (cmd.scan_start) begin
      scan_r <= '0;
      found_r <= 1'b0;
      best_el_r <= '0;
    end else if (cmd.scan_step) begin
      scan_r <= scan_r + 1'b1;
      if (better) begin
        found_r <= 1'b1;
        best_r <= sidx;
        best_el_r <= el;
      end
    end
    if (!rst_n) begin
      rcount_r <= '0;
      rpos_r <= '0;
      now_r <= '0;
      svalid_r <= '0;
      nres_r <= '0;
      pend_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cmd.do_soon && rcount_r < RCNT_W'(READY_DEPTH)) rcount_r <= rcount_r + 1'b1;
      if (cmd.do_later && free_found) svalid_r[free_idx] <= 1'b1;
      if (cmd.do_tick) begin
        now_r <= now_r + 1'b1;
        rpos_r <= '0;
        nres_r <= '0;
      end
      if (cmd.emit_ready) begin
        rpos_r <= rpos_r + 1'b1;
        nres_r <= nres_r + 1'b1;
      end
      if (cmd.emit_sleep) begin
        svalid_r[best_r] <= 1'b0;
        nres_r <= nres_r + 1'b1;
      end
      if (cmd.scan_start) begin
        rcount_r <= '0;
      end
      if (cmd.emit_ready || cmd.emit_sleep) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
      if (load_out) begin
        ov_r <= 1'b1;
      end else if (cmd.out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_task = otask_r;
  assign out_last = olast_r;
endmodule

// ----- src/rtts_ctrl.sv -----
// Controller state machine of the scheduler.
// Depends on rtts_pkg; drives rtts_datapath through rtts_cmd_t.
module rtts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                out_tready,
  input  rtts_pkg::rtts_sts_t sts,
  output rtts_pkg::rtts_cmd_t cmd
);
  import rtts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_READY = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_FLUSH = 7'b0100000,
    S_ACK   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic take, out_free, room;

  assign take = sts.out_full && out_tready;
  assign out_free = !sts.out_full || take;
  assign room = !sts.pend_full || out_free;

  always_comb begin
    cmd = '0;
    cmd.out_take = take;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          case (sts.req)
            REQ_SOON: begin
              cmd.do_soon = 1'b1;
              state_nxt = S_ACK;
            end
            REQ_LATER: begin
              cmd.do_later = 1'b1;
              state_nxt = S_ACK;
            end
            REQ_TICK: begin
              cmd.do_tick = 1'b1;
              state_nxt = S_READY;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACK: begin
        if (take) state_nxt = S_IDLE;
      end
      S_READY: begin
        if (sts.ready_left && sts.budget_left) begin
          if (room) cmd.emit_ready = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (sts.found && sts.budget_left) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_EMIT: begin
        if (room) begin
          cmd.emit_sleep = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_full) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ----- src/ready_and_timer_task_scheduler.sv -----
// Top level of the ready and timer task scheduler.
// Depends on rtts_pkg, rtts_ctrl and rtts_datapath.
//
// Requests enter on the in_ stream: call_soon queues a task, call_later parks
// it with a deadline, tick advances time and dispatches tasks. Results leave
// on the out_ stream. A request is taken in an idle cycle and executed once
// the output register is free; its acknowledge is then registered there, and
// the next request is taken only after the previous one is finished. A tick
// sends the ready tasks in queue order, one per cycle while the receiver keeps
// up, then for each due sleeping task scans all SLEEP_DEPTH slots (one per
// cycle) and sends the earliest; a tick sends at most MAX_RESULTS results.
// The newest dispatch waits in a staging register until the next one is known
// or the tick ends, so the final result of a request carries tlast. One result
// waits in the output register; when the receiver stalls, work halts until it
// is taken. After reset both stores are empty and time is zero.
module ready_and_timer_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // task_id[7:0], delay_ticks[23:8]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_task[7:0]
  output logic [1:0]  out_tuser,  // result_kind[1:0]
  output logic        out_tlast
);
  import rtts_pkg::*;

  rtts_cmd_t cmd;
  rtts_sts_t sts;

  rtts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tready(out_tready), .sts(sts), .cmd(cmd)
  );

  rtts_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_req_type(in_tuser), .in_task_id(in_tdata[7:0]),
    .in_delay_ticks(in_tdata[23:8]), .cmd(cmd), .sts(sts), .out_valid(out_tvalid),
    .out_kind(out_tuser), .out_task(out_tdata), .out_last(out_tlast)
  );
endmodule
